>>> src/spmp_pkg.sv
package spmp_pkg;

   localparam int QueueDepthDefault = 4;
   localparam int WinDepth = 8;
   localparam logic [7:0] MaxBytesReset = 8'd200;

   typedef struct packed {
      logic [7:0]  servo_id;
      logic [11:0] position;
   } spmp_match_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] index;
   } spmp_axis_type;

   localparam logic [7:0] AxisIds [16] = '{
      8'h0C, 8'h1E, 8'h01, 8'h03, 8'h17, 8'h08, 8'h0E, 8'h0A,
      8'h20, 8'h10, 8'h19, 8'h1F, 8'h12, 8'h04, 8'h05, 8'h15
   };

   function automatic spmp_axis_type axis_lookup(input logic [7:0] id);
      spmp_axis_type result;
      result = '0;
      for (int k = 15; k >= 0; k--) begin
         if (AxisIds[k] == id) begin
            result.valid = 1'b1;
            result.index = 4'(k);
         end
      end
      return result;
   endfunction

endpackage

>>> src/servo_position_message_parser.sv
// Channel | Direction | tdata (low bit up)                              | tuser      | tlast
// req     | in        | byte_value[7:0]                                 | -          | packet_end
// rsp     | out       | servo_id[7:0], position[19:8], axis_index[23:20], | axis_valid | -
//         |           | angle_q8[42:24], zero fill [47:43]              |            |
// csr     | in        | csr_wr_data = max_packet_bytes[7:0]             | -          | -
//
// One byte is taken every cycle while the result queue has room; a result is registered in the
// queue, then in back-end stages s1 and s2. The front window shifts on each byte below the limit.
// Reset clears the window, byte count, queue and pipeline, and sets the limit to 200.
// req_tready drops only when the result queue is full, which happens while rsp_tready is held low.
module servo_position_message_parser #(
   parameter int QueueDepth = spmp_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // servo_id, position, axis_index, angle_q8, zero fill
   output logic        rsp_tuser,   // axis_valid
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import spmp_pkg::*;

   logic [7:0]         max_bytes_ff, max_bytes_in;
   logic               q_push, q_in_ready, q_pop_valid, q_pop_ready;
   spmp_match_type     q_push_data, q_pop_data;
   logic [7:0]         servo_id;
   logic [11:0]        position;
   logic               axis_valid;
   logic [3:0]         axis_index;
   logic signed [18:0] angle_q8;

   assign max_bytes_in = csr_wr_en ? csr_wr_data : max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MaxBytesReset;
      end else begin
         max_bytes_ff <= max_bytes_in;
      end
   end

   spmp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .max_bytes   (max_bytes_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .byte_value  (req_tdata),
      .packet_end  (req_tlast),
      .match_valid (q_push),
      .match_data  (q_push_data),
      .match_ready (q_in_ready)
   );

   spmp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_ready (q_in_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   spmp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_pop_valid),
      .in_ready   (q_pop_ready),
      .in_data    (q_pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .servo_id   (servo_id),
      .position   (position),
      .axis_valid (axis_valid),
      .axis_index (axis_index),
      .angle_q8   (angle_q8)
   );

   assign rsp_tdata = {5'b0, angle_q8, axis_index, position, servo_id};
   assign rsp_tuser = axis_valid;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_in_ready) else $error("result queue written while full");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result shown right after reset");

   a_unknown_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[23:20] == 4'd0 && rsp_tdata[42:24] == 19'd0))
      else $error("unknown axis carries nonzero axis or angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[42:24]) >= -19'sd184320 &&
                      $signed(rsp_tdata[42:24]) <= 19'sd184320))
      else $error("angle out of range");

endmodule

>>> src/spmp_front.sv
module spmp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               max_bytes,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [7:0]               byte_value,
   input  logic                     packet_end,
   output logic                     match_valid,
   output spmp_pkg::spmp_match_type match_data,
   input  logic                     match_ready
);
   import spmp_pkg::*;

   localparam logic [7:0] CharP = 8'h50;
   localparam logic [7:0] CharO = 8'h4F;
   localparam logic [7:0] CharS = 8'h53;

   logic [7:0] win_ff [WinDepth];
   logic [7:0] win_in [WinDepth];
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic       accept;
   logic       hit;

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end
      return v;
   endfunction

   assign in_ready = match_ready;
   assign accept   = in_valid && match_ready;

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      hit      = 1'b0;
      if (accept) begin
         if (count_ff < max_bytes) begin
            hit = (count_ff >= 8'(WinDepth)) && (win_ff[0] == CharP) &&
                  (win_ff[1] == CharO) && (win_ff[2] == CharS);
            for (int i = 0; i < WinDepth - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[WinDepth - 1] = byte_value;
            count_in = count_ff + 8'd1;
         end
         if (packet_end) begin
            win_in   = '{default: '0};
            count_in = '0;
         end
      end
   end

   assign match_valid         = hit;
   assign match_data.servo_id = {hex_val(win_ff[3]), hex_val(win_ff[4])};
   assign match_data.position = {hex_val(win_ff[6]), hex_val(win_ff[7]), hex_val(byte_value)};

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '{default: '0};
         count_ff <= '0;
      end else begin
         win_ff   <= win_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/spmp_queue.sv
module spmp_queue #(
   parameter int Depth = spmp_pkg::QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  spmp_pkg::spmp_match_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output spmp_pkg::spmp_match_type pop_data
);
   import spmp_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   spmp_match_type mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/spmp_back.sv
module spmp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  spmp_pkg::spmp_match_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [7:0]               servo_id,
   output logic [11:0]              position,
   output logic                     axis_valid,
   output logic [3:0]               axis_index,
   output logic signed [18:0]       angle_q8
);
   import spmp_pkg::*;

   localparam logic [3:0] AxisShortA = 4'd2;
   localparam logic [3:0] AxisShortB = 4'd7;
   localparam logic [3:0] AxisMirrorA = 4'd4;
   localparam logic [3:0] AxisMirrorB = 4'd9;
   localparam logic [3:0] AxisQuarter = 4'd13;
   localparam logic signed [19:0] Offset90 = 20'sd23040;
   localparam logic signed [19:0] Offset30 = 20'sd7680;
   localparam logic [5:0] StepQ8 = 6'd45;

   logic                  s1_v_ff, s1_v_in;
   spmp_match_type        s1_data_ff, s1_data_in;
   spmp_axis_type         s1_axis_ff, s1_axis_in;
   logic [17:0]           s1_prod_ff, s1_prod_in;

   logic                  s2_v_ff, s2_v_in;
   logic [7:0]            s2_id_ff, s2_id_in;
   logic [11:0]           s2_pos_ff, s2_pos_in;
   spmp_axis_type         s2_axis_ff, s2_axis_in;
   logic signed [18:0]    s2_angle_ff, s2_angle_in;

   logic                  s2_ready;
   logic signed [19:0]    base;
   logic signed [19:0]    angle;

   assign s2_ready = !s2_v_ff || out_ready;
   assign in_ready = !s1_v_ff || s2_ready;

   always_comb begin
      s1_v_in    = s1_v_ff;
      s1_data_in = s1_data_ff;
      s1_axis_in = s1_axis_ff;
      s1_prod_in = s1_prod_ff;
      if (in_ready) begin
         s1_v_in    = in_valid;
         s1_data_in = in_data;
         s1_axis_in = axis_lookup(in_data.servo_id);
         s1_prod_in = 18'(in_data.position) * 18'(StepQ8);
      end
   end

   always_comb begin
      base  = $signed({2'b00, s1_prod_ff}) - Offset90;
      angle = '0;
      if (s1_axis_ff.valid) begin
         unique case (s1_axis_ff.index)
            AxisShortA, AxisShortB: angle = base - Offset30;
            AxisMirrorA, AxisMirrorB: angle = -Offset90 - base;
            AxisQuarter: angle = base - Offset90;
            default: angle = base;
         endcase
      end
   end

   always_comb begin
      s2_v_in     = s2_v_ff;
      s2_id_in    = s2_id_ff;
      s2_pos_in   = s2_pos_ff;
      s2_axis_in  = s2_axis_ff;
      s2_angle_in = s2_angle_ff;
      if (s2_ready) begin
         s2_v_in     = s1_v_ff;
         s2_id_in    = s1_data_ff.servo_id;
         s2_pos_in   = s1_data_ff.position;
         s2_axis_in  = s1_axis_ff;
         s2_angle_in = angle[18:0];
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      s1_axis_ff  <= s1_axis_in;
      s1_prod_ff  <= s1_prod_in;
      s2_id_ff    <= s2_id_in;
      s2_pos_ff   <= s2_pos_in;
      s2_axis_ff  <= s2_axis_in;
      s2_angle_ff <= s2_angle_in;
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   assign out_valid  = s2_v_ff;
   assign servo_id   = s2_id_ff;
   assign position   = s2_pos_ff;
   assign axis_valid = s2_axis_ff.valid;
   assign axis_index = s2_axis_ff.index;
   assign angle_q8   = s2_angle_ff;

endmodule

>>> tb/servo_position_message_parser_test.sv
module servo_position_message_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CharP = 8'h50;
   localparam logic [7:0] CharO = 8'h4F;
   localparam logic [7:0] CharS = 8'h53;
   localparam logic [7:0] Char0 = 8'h30;
   localparam logic [7:0] Char9 = 8'h39;
   localparam logic [7:0] CharA = 8'h41;
   localparam logic [7:0] CharF = 8'h46;

   localparam int AngleStepQ8 = 45;
   localparam int RightAngleQ8 = 23040;
   localparam int TiltOffsetQ8 = 7680;
   localparam int AxisTiltA = 2;
   localparam int AxisTiltB = 7;
   localparam int AxisMirrorA = 4;
   localparam int AxisMirrorB = 9;
   localparam int AxisTurn = 13;
   localparam int SettlePause = 12;
   localparam int PhaseItems = 170;

   localparam logic [7:0] ServoIdTable [16] = '{
      8'h0C, 8'h1E, 8'h01, 8'h03, 8'h17, 8'h08, 8'h0E, 8'h0A,
      8'h20, 8'h10, 8'h19, 8'h1F, 8'h12, 8'h04, 8'h05, 8'h15
   };

   typedef struct {
      logic [7:0] data;
      logic       last;
   } packet_byte_type;

   typedef struct {
      logic [7:0]  servo_id;
      logic [11:0] position;
      logic        axis_valid;
      logic [3:0]  axis_index;
      logic [18:0] angle_q8;
   } servo_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   packet_byte_type   pending_bytes[$];
   servo_reading_type expected_readings[$];

   logic [7:0] msg_window [spmp_pkg::WinDepth];
   logic [7:0] packet_count = '0;
   logic [7:0] packet_limit = spmp_pkg::MaxBytesReset;

   int mismatch_count = 0;
   int queued_bytes = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   servo_position_message_parser dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c >= Char0 && c <= Char9) begin
         return 4'(c - Char0);
      end else if (c >= CharA && c <= CharF) begin
         return 4'(c - CharA + 8'd10);
      end
      return 4'd0;
   endfunction

   function automatic logic [7:0] hex_char(input int v);
      return (v < 10) ? Char0 + 8'(v) : CharA + 8'(v - 10);
   endfunction

   function automatic logic [7:0] digit_char();
      if ($urandom_range(0, 99) < 88) begin
         return hex_char($urandom_range(0, 15));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advances the parser state by one byte and queues the reading it completes.
   task automatic parse_byte(input logic [7:0] b, input logic last);
      servo_reading_type r;
      int base;
      int ang;
      if (packet_count < packet_limit) begin
         if (packet_count >= spmp_pkg::WinDepth && msg_window[0] == CharP &&
               msg_window[1] == CharO && msg_window[2] == CharS) begin
            r.servo_id = {hex_value(msg_window[3]), hex_value(msg_window[4])};
            r.position = {hex_value(msg_window[6]), hex_value(msg_window[7]), hex_value(b)};
            r.axis_valid = 1'b0;
            r.axis_index = '0;
            ang = 0;
            for (int k = 0; k < 16; k++) begin
               if (!r.axis_valid && ServoIdTable[k] == r.servo_id) begin
                  r.axis_valid = 1'b1;
                  r.axis_index = 4'(k);
               end
            end
            base = int'(r.position) * AngleStepQ8 - RightAngleQ8;
            if (r.axis_valid) begin
               case (int'(r.axis_index))
                  AxisTiltA, AxisTiltB: ang = base - TiltOffsetQ8;
                  AxisMirrorA, AxisMirrorB: ang = -RightAngleQ8 - base;
                  AxisTurn: ang = base - RightAngleQ8;
                  default: ang = base;
               endcase
            end
            r.angle_q8 = ang[18:0];
            expected_readings.push_back(r);
         end
         for (int k = 0; k < spmp_pkg::WinDepth - 1; k++) begin
            msg_window[k] = msg_window[k + 1];
         end
         msg_window[spmp_pkg::WinDepth - 1] = b;
         packet_count = packet_count + 8'd1;
      end
      if (last) begin
         foreach (msg_window[k]) msg_window[k] = '0;
         packet_count = '0;
      end
   endtask

   task automatic queue_packet(ref packet_byte_type pkt[$]);
      if (pkt.size() == 0) begin
         pkt.push_back('{8'($urandom_range(0, 255)), 1'b0});
      end
      pkt[pkt.size() - 1].last = 1'b1;
      foreach (pkt[k]) pending_bytes.push_back(pkt[k]);
      queued_bytes += pkt.size();
   endtask

   task automatic queue_text(input string s);
      packet_byte_type pkt[$];
      for (int k = 0; k < s.len(); k++) pkt.push_back('{s[k], 1'b0});
      queue_packet(pkt);
   endtask

   task automatic add_message(ref packet_byte_type pkt[$], input bit broken);
      logic [7:0] msg [9];
      int id;
      int keep;
      msg[0] = CharP;
      msg[1] = CharO;
      msg[2] = CharS;
      if ($urandom_range(0, 9) < 7) begin
         id = ServoIdTable[$urandom_range(0, 15)];
         msg[3] = hex_char(id >> 4);
         msg[4] = hex_char(id & 15);
      end else begin
         msg[3] = digit_char();
         msg[4] = digit_char();
      end
      msg[5] = 8'($urandom_range(0, 255));
      msg[6] = digit_char();
      msg[7] = digit_char();
      msg[8] = digit_char();
      keep = broken ? $urandom_range(1, 8) : 9;
      for (int k = 0; k < keep; k++) pkt.push_back('{msg[k], 1'b0});
   endtask

   task automatic add_noise(ref packet_byte_type pkt[$], input int count);
      for (int k = 0; k < count; k++) pkt.push_back('{8'($urandom_range(0, 255)), 1'b0});
   endtask

   task automatic queue_random_packet();
      packet_byte_type pkt[$];
      int segments;
      segments = $urandom_range(1, 4);
      for (int s = 0; s < segments; s++) begin
         case ($urandom_range(0, 9))
            0, 1: add_noise(pkt, $urandom_range(1, 5));
            2: add_message(pkt, 1'b1);
            3: begin
               pkt.push_back('{CharP, 1'b0});
               pkt.push_back('{CharO, 1'b0});
               add_message(pkt, 1'b0);
            end
            4: begin
               pkt.push_back('{CharP, 1'b0});
               pkt.push_back('{CharO, 1'b0});
               pkt.push_back('{CharS, 1'b0});
               add_message(pkt, 1'b0);
            end
            default: add_message(pkt, 1'b0);
         endcase
      end
      queue_packet(pkt);
   endtask

   task automatic queue_long_packet();
      packet_byte_type pkt[$];
      add_noise(pkt, 10);
      for (int k = 0; k < 32; k++) add_message(pkt, 1'b0);
      queue_packet(pkt);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_bytes.size() > 0 || req_tvalid || expected_readings.size() > 0) begin
         @(posedge clock);
      end
      repeat (SettlePause) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      packet_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : byte_driver
      packet_byte_type next_byte;
      int gap_n;
      logic valid_n;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
         packet_count = '0;
         foreach (msg_window[k]) msg_window[k] = '0;
      end else begin
         valid_n = req_tvalid;
         gap_n = req_gap;
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast);
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
            valid_n = 1'b0;
            gap_n = draw_gap(req_calm);
         end
         if (!valid_n) begin
            if (gap_n > 0) begin
               gap_n--;
            end else if (pending_bytes.size() > 0) begin
               next_byte = pending_bytes.pop_front();
               req_tdata <= next_byte.data;
               req_tlast <= next_byte.last;
               valid_n = 1'b1;
            end
         end
         req_gap = gap_n;
         req_tvalid <= valid_n;
      end
   end

   always @(posedge clock) begin : reading_monitor
      servo_reading_type want;
      int stall_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         stall_n = rsp_stall;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, tdata %h", rsp_tdata));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata[7:0] !== want.servo_id)
                  report_mismatch($sformatf("servo_id %h, expected %h",
                     rsp_tdata[7:0], want.servo_id));
               if (rsp_tdata[19:8] !== want.position)
                  report_mismatch($sformatf("position %h, expected %h",
                     rsp_tdata[19:8], want.position));
               if (rsp_tuser !== want.axis_valid)
                  report_mismatch($sformatf("axis_valid %b, expected %b",
                     rsp_tuser, want.axis_valid));
               if (rsp_tdata[23:20] !== want.axis_index)
                  report_mismatch($sformatf("axis_index %0d, expected %0d",
                     rsp_tdata[23:20], want.axis_index));
               if (rsp_tdata[42:24] !== want.angle_q8)
                  report_mismatch($sformatf("angle_q8 %h, expected %h",
                     rsp_tdata[42:24], want.angle_q8));
            end
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            stall_n = draw_gap(rsp_calm);
         end else if (stall_n > 0) begin
            stall_n--;
         end
         rsp_stall = stall_n;
         rsp_tready <= (stall_n == 0);
      end
   end

   initial begin : stimulus
      logic [7:0] limits [6];
      limits = '{8'd200, 8'd9, 8'd12, 8'd255, 8'd3, 8'($urandom_range(9, 255))};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_text("POS0C.000");
      queue_text("POS01-FFF");
      queue_text("POS17:800");
      queue_text("POS0A9ABC");
      queue_text("POS10 7FF");
      queue_text("POS04.FFF");
      queue_text("POSFF/FFF");
      queue_text("POSa1.zf9");
      queue_text("POS1E");
      queue_text("POS12POS0C.ABC");
      begin
         packet_byte_type pkt[$];
         pkt.push_back('{8'h00, 1'b0});
         pkt.push_back('{8'hFF, 1'b0});
         queue_packet(pkt);
      end
      wait_idle();

      foreach (limits[p]) begin
         write_limit(limits[p]);
         queued_bytes = 0;
         if (limits[p] >= 8'd200) queue_long_packet();
         while (queued_bytes < PhaseItems) queue_random_packet();
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
